// ===== sv/kal_pkg.sv =====
package kal_pkg;

   // table geometry
   localparam int NODES   = 1024;
   localparam int LEVELS  = 10;
   localparam int FIELD_W = 10;
   localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DEPTH   = NODES * LEVELS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef logic [1:0]        mode_type;
   typedef logic [NODE_W-1:0] node_type;
   typedef logic [LVL_W-1:0]  level_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // operation codes on req_mode
   localparam mode_type MODE_LOAD  = 2'd0;
   localparam mode_type MODE_BUILD = 2'd1;
   localparam mode_type MODE_QUERY = 2'd2;

   // entry [node][level] lives at level * NODES + node
   function automatic addr_type table_addr(level_type lvl, node_type nd);
      return ADDR_W'(32'(lvl) * 32'(NODES) + 32'(nd));
   endfunction

endpackage

// ===== sv/kal_ram.sv =====
module kal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kth_ancestor_binary_lifting.sv =====
// k-th ancestor lookup over a rooted tree held as a binary-lifting jump table.
// Node 1 is the root, node 0 means no node. Entry [v][j] is the 2^j-th
// ancestor of v. One table RAM (NODES x LEVELS entries, one read and one
// write port) is shared by loading, building and querying.
// Command channel: start with req_mode/req_node/req_parent/req_distance is
// taken at a clock edge where start is high and busy is low.
//   load  (mode 0): for req_node 1..NODES-1 writes its parent in the accept
//                   cycle; busy stays low, so loads can issue every cycle.
//   build (mode 1): fills levels 1..LEVELS-1 for nodes 1..node_count, each
//                   entry by two reads and a write (BLD_A, BLD_B, BLD_W).
//   query (mode 2): walks req_distance from bit 0 up, a read and jump per set
//                   bit and a skip per clear bit; rsp_strobe rises once no
//                   distance bits remain.
// Result channel: rsp_found/rsp_ancestor are valid for exactly the one cycle
// rsp_strobe is high; there is no back-pressure, the receiver must take it.
// csr_wr_en/csr_wr_data write node_count (reset value 1) at any clock edge.
// Reset: synchronous, active high. After reset the block sweeps the table to
// zero, one entry per cycle, all NODES*LEVELS = 10240 entries, with busy high.
module kth_ancestor_binary_lifting (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic [kal_pkg::FIELD_W-1:0]  req_node,
   input  logic [kal_pkg::FIELD_W-1:0]  req_parent,
   input  logic [kal_pkg::FIELD_W-1:0]  req_distance,
   output logic                         rsp_strobe,
   output logic                         rsp_found,
   output logic [kal_pkg::FIELD_W-1:0]  rsp_ancestor,
   input  logic                         csr_wr_en,
   input  logic [kal_pkg::FIELD_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BLD_A,
      ST_BLD_B,
      ST_BLD_W,
      ST_QSCAN,
      ST_QWAIT
   } state_type;

   state_type                       state_ff, state_in;
   kal_pkg::addr_type               clr_ff, clr_in;
   kal_pkg::node_type               x_ff, x_in;
   kal_pkg::node_type               last_ff, last_in;
   kal_pkg::level_type              lvl_ff, lvl_in;
   logic [kal_pkg::FIELD_W-1:0]     dist_ff, dist_in;
   logic [kal_pkg::FIELD_W-1:0]     node_count_ff, node_count_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [kal_pkg::FIELD_W-1:0]     rsp_ancestor_ff, rsp_ancestor_in;

   logic                            ram_wr_en;
   kal_pkg::addr_type               ram_wr_addr;
   kal_pkg::node_type               ram_wr_data;
   logic                            ram_rd_en;
   kal_pkg::addr_type               ram_rd_addr;
   kal_pkg::node_type               ram_rd_data;

   logic                            node_ok;
   logic                            load_ok;
   logic                            too_far;
   kal_pkg::node_type               parent_val;
   kal_pkg::node_type               last_val;

   // decode the command fields
   always_comb begin
      node_ok    = 32'(req_node) < 32'(kal_pkg::NODES);
      load_ok    = node_ok && (req_node != '0);
      too_far    = (32'(req_distance) >> kal_pkg::LEVELS) != 32'd0;
      parent_val = (32'(req_parent) < 32'(kal_pkg::NODES)) ?
                   kal_pkg::NODE_W'(req_parent) : '0;
      last_val   = (32'(node_count_ff) > 32'(kal_pkg::NODES - 1)) ?
                   kal_pkg::NODE_W'(kal_pkg::NODES - 1) :
                   kal_pkg::NODE_W'(node_count_ff);
   end

   // sequencer: clear sweep, build pass and query walk share the table RAM
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      x_in            = x_ff;
      last_in         = last_ff;
      lvl_in          = lvl_ff;
      dist_in         = dist_ff;
      node_count_in   = csr_wr_en ? csr_wr_data : node_count_ff;
      rsp_strobe_in   = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_ancestor_in = rsp_ancestor_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = '0;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            if (clr_ff == kal_pkg::ADDR_W'(kal_pkg::DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  kal_pkg::MODE_LOAD: begin
                     ram_wr_en   = load_ok;
                     ram_wr_addr = kal_pkg::table_addr('0, kal_pkg::NODE_W'(req_node));
                     ram_wr_data = parent_val;
                  end
                  kal_pkg::MODE_BUILD: begin
                     if (kal_pkg::LEVELS > 1 && last_val != '0) begin
                        lvl_in   = kal_pkg::LVL_W'(1);
                        x_in     = kal_pkg::NODE_W'(1);
                        last_in  = last_val;
                        state_in = ST_BLD_A;
                     end
                  end
                  kal_pkg::MODE_QUERY: begin
                     // an out-of-range node or distance walks nothing and reports zero
                     x_in     = (node_ok && !too_far) ? kal_pkg::NODE_W'(req_node) : '0;
                     dist_in  = (node_ok && !too_far) ? req_distance : '0;
                     lvl_in   = '0;
                     state_in = ST_QSCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // build: read this node's entry at the level below
         ST_BLD_A: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = kal_pkg::table_addr(lvl_ff - 1'b1, x_ff);
            state_in    = ST_BLD_B;
         end
         // build: read the midpoint's entry at level below
         ST_BLD_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = kal_pkg::table_addr(lvl_ff - 1'b1, ram_rd_data);
            state_in    = ST_BLD_W;
         end
         // build: store and advance node, then level
         ST_BLD_W: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = kal_pkg::table_addr(lvl_ff, x_ff);
            ram_wr_data = ram_rd_data;
            state_in    = ST_BLD_A;
            if (x_ff == last_ff) begin
               x_in = kal_pkg::NODE_W'(1);
               if (lvl_ff == kal_pkg::LVL_W'(kal_pkg::LEVELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in = lvl_ff + 1'b1;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         // query: finish when no distance bits remain, else jump or skip
         ST_QSCAN: begin
            if (dist_ff == '0) begin
               rsp_strobe_in   = 1'b1;
               rsp_found_in    = x_ff != '0;
               rsp_ancestor_in = kal_pkg::FIELD_W'(x_ff);
               state_in        = ST_IDLE;
            end else if (dist_ff[0]) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = kal_pkg::table_addr(lvl_ff, x_ff);
               state_in    = ST_QWAIT;
            end else begin
               dist_in = dist_ff >> 1;
               lvl_in  = lvl_ff + 1'b1;
            end
         end
         // query: take the jump; reaching node 0 ends the walk as not found
         ST_QWAIT: begin
            x_in     = ram_rd_data;
            dist_in  = (ram_rd_data == '0) ? '0 : (dist_ff >> 1);
            lvl_in   = lvl_ff + 1'b1;
            state_in = ST_QSCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= kal_pkg::FIELD_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         node_count_ff <= node_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      x_ff            <= x_in;
      last_ff         <= last_in;
      lvl_ff          <= lvl_in;
      dist_ff         <= dist_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
   end

   kal_ram #(
      .WIDTH (kal_pkg::NODE_W),
      .DEPTH (kal_pkg::DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy         = state_ff != ST_IDLE;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_ancestor = rsp_ancestor_ff;

   // a result beat only comes out of the end of a query walk
   a_strobe_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_QSCAN))
      else $error("result beat without a finished walk");

   // found flag agrees with the reported ancestor
   a_found_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_found == (rsp_ancestor != '0)))
      else $error("found flag disagrees with ancestor");

   // a query walk never writes the table
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QSCAN || state_ff == ST_QWAIT) |-> !ram_wr_en)
      else $error("table written during query");

   // leaving reset starts the clear sweep with the block busy
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (busy && clr_ff == '0))
      else $error("not clearing after reset");

   // build never reads and writes the RAM in the same cycle
   a_build_ports: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLD_A || state_ff == ST_BLD_B || state_ff == ST_BLD_W)
      |-> !(ram_rd_en && ram_wr_en))
      else $error("build port conflict");

endmodule
